FILE: rtl/dtm_pkg.sv
// dtm_pkg: shared types and constants for the dual timer with match interrupt
`timescale 1ns / 1ps

package dtm_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int MATCH_WORDS    = 6;
    localparam int CTL_BITS       = 5;
    localparam int IRQ_BITS       = 6;
    localparam int DATA_BITS      = 32;

    localparam int CTL_UP   = 3;
    localparam int CTL_STOP = 4;

    localparam logic [2:0] MODE_HOLD = 3'd0;
    localparam logic [2:0] MODE_FREE = 3'd7;

    localparam logic SPACE_TIMER = 1'b0;
    localparam logic SPACE_IRQ   = 1'b1;

    localparam logic [5:0] OFF_VALUE0      = 6'h00;
    localparam logic [5:0] OFF_DIVIDER0    = 6'h04;
    localparam logic [5:0] OFF_CONTROL0    = 6'h08;
    localparam logic [5:0] OFF_VALUE1      = 6'h0C;
    localparam logic [5:0] OFF_DIVIDER1    = 6'h10;
    localparam logic [5:0] OFF_CONTROL1    = 6'h14;
    localparam logic [5:0] OFF_MATCH_FIRST = 6'h18;
    localparam logic [5:0] OFF_MATCH_LAST  = 6'h2C;
    localparam logic [5:0] OFF_SPARE       = 6'h30;
    localparam logic [5:0] OFF_IRQ_STATUS  = 6'h00;
    localparam logic [5:0] OFF_IRQ_MASK    = 6'h04;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]           operation;
        logic                 reg_space;
        logic [5:0]           reg_offset;
        logic [DATA_BITS-1:0] write_data;
    } t_in;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 bad_access;
        logic                 irq;
    } t_out;

    typedef struct packed {
        logic tick;
        logic wr_value;
        logic wr_divider;
        logic wr_control;
    } t_tmr_ctl;

endpackage

FILE: rtl/dtm_timer.sv
// dtm_timer: one counter with reload, prescaler and mode control
`timescale 1ns / 1ps

module dtm_timer #(
    parameter int COUNT_BITS = dtm_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtm_pkg::t_tmr_ctl            i_ctl,
    input  logic [COUNT_BITS-1:0]        i_wdata,
    input  logic [dtm_pkg::CTL_BITS-1:0] i_wctl,
    input  logic [COUNT_BITS-1:0]        i_match [dtm_pkg::MATCH_WORDS],
    output logic [COUNT_BITS-1:0]        o_value,
    output logic [COUNT_BITS-1:0]        o_divider,
    output logic [dtm_pkg::CTL_BITS-1:0] o_control,
    output logic                         o_step,
    output logic [COUNT_BITS-1:0]        o_value_next
);
    import dtm_pkg::*;

    logic [COUNT_BITS-1:0] r_value;
    logic [COUNT_BITS-1:0] r_reload;
    logic [COUNT_BITS-1:0] r_divider;
    logic [COUNT_BITS-1:0] r_pcount;
    logic [CTL_BITS-1:0]   r_control;

    logic [COUNT_BITS:0]   n_pcount;
    logic [COUNT_BITS-1:0] n_value;
    logic [COUNT_BITS-1:0] cmp_word;
    logic [2:0]            mode;
    logic                  run;
    logic                  step;

    assign mode     = r_control[2:0];
    assign run      = i_ctl.tick && !r_control[CTL_STOP];
    assign n_pcount = {1'b0, r_pcount} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign step     = run && (n_pcount > {1'b0, r_divider});

    always_comb begin
        unique case (mode)
            3'd1:    cmp_word = i_match[0];
            3'd2:    cmp_word = i_match[1];
            3'd3:    cmp_word = i_match[2];
            3'd4:    cmp_word = i_match[3];
            3'd5:    cmp_word = i_match[4];
            3'd6:    cmp_word = i_match[5];
            default: cmp_word = '0;
        endcase

        priority if (mode == MODE_HOLD && r_value == '0) begin
            n_value = r_value;
        end else if (mode != MODE_HOLD && mode != MODE_FREE && r_value == cmp_word) begin
            n_value = r_reload;
        end else if (r_control[CTL_UP]) begin
            n_value = r_value + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end else begin
            n_value = r_value - {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value   <= '0;
            r_reload  <= '0;
            r_divider <= '0;
            r_pcount  <= '0;
            r_control <= '0;
        end else begin
            if (run) begin
                if (step) begin
                    r_pcount <= '0;
                    r_value  <= n_value;
                end else begin
                    r_pcount <= n_pcount[COUNT_BITS-1:0];
                end
            end
            if (i_ctl.wr_value) begin
                r_value  <= i_wdata;
                r_reload <= i_wdata;
            end
            if (i_ctl.wr_divider) begin
                r_divider <= i_wdata;
            end
            if (i_ctl.wr_control) begin
                r_control <= i_wctl;
            end
        end
    end

    assign o_value      = r_value;
    assign o_divider    = r_divider;
    assign o_control    = r_control;
    assign o_step       = step;
    assign o_value_next = n_value;

endmodule

FILE: rtl/dual_timer_with_match_irq.sv
// dual_timer_with_match_irq: two timers, shared match words and interrupt registers
// a transaction is held in the input register and then its result in the output register
// throughput: one transaction per cycle, reads, writes and ticks alike, while the output is not stalled
// each transaction is decoded from its input register and applied when it passes to the output register
// output stall backs up through the input register into o_in_stall
// synchronous reset clears all counters, match words, status and mask to zero
`timescale 1ns / 1ps

module dual_timer_with_match_irq #(
    parameter int COUNT_BITS = dtm_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  dtm_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output dtm_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import dtm_pkg::*;

    logic                  r_in_valid;
    t_in                   r_in;
    logic                  r_out_valid;
    t_out                  r_out;
    logic [COUNT_BITS-1:0] r_match [MATCH_WORDS];
    logic [IRQ_BITS-1:0]   r_status;
    logic [IRQ_BITS-1:0]   r_mask;

    logic                  out_free;
    logic                  fire;
    logic                  in_acc;
    t_out                  n_out;
    logic [DATA_BITS-1:0]  rdata;
    logic                  bad;
    logic [IRQ_BITS-1:0]   bus_status;
    logic [IRQ_BITS-1:0]   n_status;
    logic [IRQ_BITS-1:0]   n_mask;
    logic [IRQ_BITS-1:0]   hits;
    t_tmr_ctl              tmr_ctl [2];
    logic                  wr_match;
    logic                  match_ok;
    logic [2:0]            match_idx;
    logic [5:0]            match_off;
    logic [COUNT_BITS-1:0] wdata;
    logic [CTL_BITS-1:0]   wctl;

    logic [COUNT_BITS-1:0] t_value   [2];
    logic [COUNT_BITS-1:0] t_divider [2];
    logic [CTL_BITS-1:0]   t_control [2];
    logic [COUNT_BITS-1:0] t_next    [2];
    logic                  t_step    [2];

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign wdata     = r_in.write_data[COUNT_BITS-1:0];
    assign wctl      = r_in.write_data[CTL_BITS-1:0];
    assign match_off = r_in.reg_offset - OFF_MATCH_FIRST;
    assign match_idx = match_off[4:2];
    assign match_ok  = (r_in.reg_offset >= OFF_MATCH_FIRST)
                    && (r_in.reg_offset <= OFF_MATCH_LAST)
                    && (r_in.reg_offset[1:0] == 2'b00);

    // register decode
    always_comb begin
        rdata      = '0;
        bad        = 1'b0;
        tmr_ctl[0] = '0;
        tmr_ctl[1] = '0;
        wr_match   = 1'b0;
        bus_status = r_status;
        n_mask     = r_mask;

        unique case (t_op'(r_in.operation))
            OP_READ: begin
                if (r_in.reg_space == SPACE_TIMER) begin
                    unique case (r_in.reg_offset)
                        OFF_VALUE0:   rdata = DATA_BITS'(t_value[0]);
                        OFF_DIVIDER0: rdata = DATA_BITS'(t_divider[0]);
                        OFF_CONTROL0: rdata = DATA_BITS'(t_control[0]);
                        OFF_VALUE1:   rdata = DATA_BITS'(t_value[1]);
                        OFF_DIVIDER1: rdata = DATA_BITS'(t_divider[1]);
                        OFF_CONTROL1: rdata = DATA_BITS'(t_control[1]);
                        default: begin
                            if (match_ok) begin
                                rdata = DATA_BITS'(r_match[match_idx]);
                            end else begin
                                bad = 1'b1;
                            end
                        end
                    endcase
                end else begin
                    priority if (r_in.reg_offset == OFF_IRQ_STATUS) begin
                        rdata = DATA_BITS'(r_status);
                    end else if (r_in.reg_offset == OFF_IRQ_MASK) begin
                        rdata = DATA_BITS'(r_mask);
                    end else begin
                        bad = 1'b1;
                    end
                end
            end
            OP_WRITE: begin
                if (r_in.reg_space == SPACE_TIMER) begin
                    unique case (r_in.reg_offset)
                        OFF_VALUE0:   tmr_ctl[0].wr_value   = 1'b1;
                        OFF_DIVIDER0: tmr_ctl[0].wr_divider = 1'b1;
                        OFF_CONTROL0: tmr_ctl[0].wr_control = 1'b1;
                        OFF_VALUE1:   tmr_ctl[1].wr_value   = 1'b1;
                        OFF_DIVIDER1: tmr_ctl[1].wr_divider = 1'b1;
                        OFF_CONTROL1: tmr_ctl[1].wr_control = 1'b1;
                        OFF_SPARE:    ;
                        default: begin
                            if (match_ok) begin
                                wr_match = 1'b1;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                    endcase
                end else begin
                    priority if (r_in.reg_offset == OFF_IRQ_STATUS) begin
                        bus_status = r_status & ~r_in.write_data[IRQ_BITS-1:0];
                    end else if (r_in.reg_offset == OFF_IRQ_MASK) begin
                        n_mask = r_in.write_data[IRQ_BITS-1:0];
                    end else begin
                        bad = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                tmr_ctl[0].tick = 1'b1;
                tmr_ctl[1].tick = 1'b1;
            end
            default: ;
        endcase

        if (!fire) begin
            tmr_ctl[0] = '0;
            tmr_ctl[1] = '0;
            wr_match   = 1'b0;
        end
    end

    // timer 0 match test after its step
    always_comb begin
        for (int k = 0; k < MATCH_WORDS; k++) begin
            hits[k] = t_step[0] && (t_next[0] == r_match[k]);
        end
    end

    assign n_status = bus_status | hits;
    assign n_out    = {rdata, bad, |(n_status & n_mask)};

    for (genvar g = 0; g < 2; g++) begin : g_timer
        dtm_timer #(
            .COUNT_BITS (COUNT_BITS)
        ) u_timer (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (tmr_ctl[g]),
            .i_wdata      (wdata),
            .i_wctl       (wctl),
            .i_match      (r_match),
            .o_value      (t_value[g]),
            .o_divider    (t_divider[g]),
            .o_control    (t_control[g]),
            .o_step       (t_step[g]),
            .o_value_next (t_next[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= '0;
            r_mask      <= '0;
            for (int k = 0; k < MATCH_WORDS; k++) begin
                r_match[k] <= '0;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_status <= n_status;
                r_mask   <= n_mask;
            end
            if (wr_match) begin
                r_match[match_idx] <= wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/dtm_checker.sv
// dtm_checker: port-level checks for dual_timer_with_match_irq, with bind
`timescale 1ns / 1ps

module dtm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input dtm_pkg::t_in  i_in_data,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input dtm_pkg::t_out o_out_data,
    input logic          i_out_stall
);
    import dtm_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a bad access never returns data
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bad_access |-> o_out_data.read_data == '0)
        else $error("bad access with nonzero read data");

    // input backs up only behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    // an accepted transaction reaches the output when the output keeps moving
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted transaction produced no result");

endmodule

bind dual_timer_with_match_irq dtm_checker u_dtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

FILE: sim/dual_timer_with_match_irq_tb.sv
// dual_timer_with_match_irq_tb: self-checking testbench for the dual timer with match interrupt
`timescale 1ns / 1ps

module dual_timer_with_match_irq_tb;
    import dtm_pkg::*;

    localparam int CB = COUNT_BITS_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 48;
    localparam int MAX_REPORTS = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_data = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    dual_timer_with_match_irq dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(out_stall)
    );

    always #5 i_clk = ~i_clk;

    // timer pair state as the block should hold it
    logic [CB-1:0] tmr_value[2];
    logic [CB-1:0] tmr_reload[2];
    logic [CB-1:0] tmr_divider[2];
    logic [CB-1:0] tmr_prescale[2];
    logic [CTL_BITS-1:0] tmr_control[2];
    logic [CB-1:0] match_words[MATCH_WORDS];
    logic [IRQ_BITS-1:0] irq_status;
    logic [IRQ_BITS-1:0] irq_mask;

    t_out expected_results[$];
    bit idle_on = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;
    int rx_hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int result_count = 0;
    int tick_count = 0;
    int bad_seen = 0;
    int irq_seen = 0;

    function automatic void clear_timer_state();
        for (int i = 0; i < 2; i++) begin
            tmr_value[i] = '0;
            tmr_reload[i] = '0;
            tmr_divider[i] = '0;
            tmr_prescale[i] = '0;
            tmr_control[i] = '0;
        end
        for (int k = 0; k < MATCH_WORDS; k++) match_words[k] = '0;
        irq_status = '0;
        irq_mask = '0;
    endfunction

    function automatic void step_timer(input int t);
        logic [2:0] mode;
        logic [CB-1:0] v;
        mode = tmr_control[t][2:0];
        v = tmr_value[t];
        if (mode == MODE_HOLD && v == '0) begin
            v = '0;
        end else if (mode != MODE_HOLD && mode != MODE_FREE && v == match_words[int'(mode) - 1]) begin
            v = tmr_reload[t];
        end else if (tmr_control[t][CTL_UP]) begin
            v = v + CB'(1);
        end else begin
            v = v - CB'(1);
        end
        tmr_value[t] = v;
        if (t == 0) begin
            for (int k = 0; k < MATCH_WORDS; k++)
                if (v == match_words[k]) irq_status[k] = 1'b1;
        end
    endfunction

    function automatic void tick_timers();
        logic [CB:0] next_count;
        for (int t = 0; t < 2; t++) begin
            if (!tmr_control[t][CTL_STOP]) begin
                next_count = {1'b0, tmr_prescale[t]} + (CB+1)'(1);
                if (next_count > {1'b0, tmr_divider[t]}) begin
                    tmr_prescale[t] = '0;
                    step_timer(t);
                end else begin
                    tmr_prescale[t] = next_count[CB-1:0];
                end
            end
        end
    endfunction

    function automatic logic is_match_offset(input logic [5:0] off);
        return off >= OFF_MATCH_FIRST && off <= OFF_MATCH_LAST && off[1:0] == 2'b00;
    endfunction

    function automatic logic read_timer_reg(input logic [5:0] off, output logic [31:0] data);
        data = '0;
        case (off)
            OFF_VALUE0:   data = 32'(tmr_value[0]);
            OFF_DIVIDER0: data = 32'(tmr_divider[0]);
            OFF_CONTROL0: data = 32'(tmr_control[0]);
            OFF_VALUE1:   data = 32'(tmr_value[1]);
            OFF_DIVIDER1: data = 32'(tmr_divider[1]);
            OFF_CONTROL1: data = 32'(tmr_control[1]);
            default: begin
                if (!is_match_offset(off)) return 1'b0;
                data = 32'(match_words[(off - OFF_MATCH_FIRST) >> 2]);
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic write_timer_reg(input logic [5:0] off, input logic [31:0] val);
        case (off)
            OFF_VALUE0: begin
                tmr_reload[0] = val[CB-1:0];
                tmr_value[0] = val[CB-1:0];
            end
            OFF_DIVIDER0: tmr_divider[0] = val[CB-1:0];
            OFF_CONTROL0: tmr_control[0] = val[CTL_BITS-1:0];
            OFF_VALUE1: begin
                tmr_reload[1] = val[CB-1:0];
                tmr_value[1] = val[CB-1:0];
            end
            OFF_DIVIDER1: tmr_divider[1] = val[CB-1:0];
            OFF_CONTROL1: tmr_control[1] = val[CTL_BITS-1:0];
            OFF_SPARE: ;
            default: begin
                if (!is_match_offset(off)) return 1'b0;
                match_words[(off - OFF_MATCH_FIRST) >> 2] = val[CB-1:0];
            end
        endcase
        return 1'b1;
    endfunction

    function automatic t_out timer_pair_response(input t_in txn);
        t_out r;
        logic ok;
        r = '0;
        ok = 1'b1;
        case (txn.operation)
            OP_READ: begin
                if (txn.reg_space == SPACE_TIMER) ok = read_timer_reg(txn.reg_offset, r.read_data);
                else if (txn.reg_offset == OFF_IRQ_STATUS) r.read_data = 32'(irq_status);
                else if (txn.reg_offset == OFF_IRQ_MASK) r.read_data = 32'(irq_mask);
                else ok = 1'b0;
                if (!ok) r.read_data = '0;
            end
            OP_WRITE: begin
                if (txn.reg_space == SPACE_TIMER) ok = write_timer_reg(txn.reg_offset, txn.write_data);
                else if (txn.reg_offset == OFF_IRQ_STATUS) irq_status &= ~txn.write_data[IRQ_BITS-1:0];
                else if (txn.reg_offset == OFF_IRQ_MASK) irq_mask = txn.write_data[IRQ_BITS-1:0];
                else ok = 1'b0;
            end
            OP_TICK: tick_timers();
            default: ;
        endcase
        r.bad_access = !ok;
        r.irq = |(irq_status & irq_mask);
        return r;
    endfunction

    function automatic t_in make_txn(input logic [1:0] op, input logic space,
                                     input logic [5:0] off, input logic [31:0] data);
        t_in txn;
        txn.operation = op;
        txn.reg_space = space;
        txn.reg_offset = off;
        txn.write_data = data;
        return txn;
    endfunction

    function automatic t_in random_txn();
        t_in txn;
        int pick;
        pick = $urandom_range(0, 99);
        txn = make_txn(OP_TICK, 1'($urandom), 6'($urandom), $urandom);
        if (pick < 40) begin
            return txn;
        end else if (pick < 80) begin
            txn.operation = (pick < 62) ? OP_WRITE : OP_READ;
            txn.reg_space = SPACE_TIMER;
            txn.reg_offset = 6'($urandom_range(0, 11) << 2);
            if ($urandom_range(0, 4) != 0) txn.write_data = $urandom_range(0, 12);
            case (txn.reg_offset)
                OFF_DIVIDER0, OFF_DIVIDER1:
                    if ($urandom_range(0, 7) != 0) txn.write_data = $urandom_range(0, 3);
                OFF_CONTROL0, OFF_CONTROL1: begin
                    txn.write_data = $urandom;
                    txn.write_data[CTL_STOP] = ($urandom_range(0, 3) == 0);
                end
                default: ;
            endcase
        end else if (pick < 88) begin
            txn.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            txn.reg_space = SPACE_IRQ;
            txn.reg_offset = $urandom_range(0, 1) ? OFF_IRQ_MASK : OFF_IRQ_STATUS;
        end else begin
            txn.operation = 2'($urandom_range(0, 3));
        end
        return txn;
    endfunction

    task automatic send_txn(input t_in txn);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= txn;
        do @(posedge i_clk); while (o_in_stall);
        if (txn.operation == OP_TICK) tick_count++;
        expected_results.push_back(timer_pair_response(txn));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_register_access();
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_VALUE0, 32'hFFFF_FFFF));
        send_txn(make_txn(OP_READ, SPACE_TIMER, OFF_VALUE0, 32'h0));
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_CONTROL1, 32'hFFFF_FFFF));
        send_txn(make_txn(OP_READ, SPACE_TIMER, OFF_CONTROL1, 32'hFFFF_FFFF));
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_MATCH_LAST, 32'h5A5A_A5A5));
        send_txn(make_txn(OP_READ, SPACE_TIMER, OFF_MATCH_LAST, 32'h0));
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_SPARE, 32'hFFFF_FFFF));
        send_txn(make_txn(OP_READ, SPACE_TIMER, OFF_SPARE, 32'h0));
        send_txn(make_txn(OP_READ, SPACE_TIMER, OFF_MATCH_FIRST + 6'd1, 32'h0));
        send_txn(make_txn(OP_READ, SPACE_TIMER, 6'h3F, 32'h0));
        send_txn(make_txn(OP_WRITE, SPACE_IRQ, 6'h08, 32'hFFFF_FFFF));
        send_txn(make_txn(OP_READ, SPACE_IRQ, OFF_IRQ_MASK, 32'h0));
        send_txn(make_txn(OP_UNUSED, SPACE_IRQ, 6'h3F, 32'hFFFF_FFFF));
        wait_drain();
    endtask

    task automatic test_timer_steps();
        // held timer at zero still matches the zero match words
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_CONTROL0, 32'h0));
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_VALUE0, 32'h0));
        send_txn(make_txn(OP_WRITE, SPACE_IRQ, OFF_IRQ_MASK, 32'hFFFF_FFFF));
        send_txn(make_txn(OP_TICK, SPACE_TIMER, 6'h0, 32'h0));
        send_txn(make_txn(OP_WRITE, SPACE_IRQ, OFF_IRQ_STATUS, 32'h0000_003F));
        // divider lowered under the running prescale count
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_VALUE0, 32'h3));
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_DIVIDER0, 32'h4));
        repeat (3) send_txn(make_txn(OP_TICK, SPACE_TIMER, 6'h0, 32'h0));
        send_txn(make_txn(OP_WRITE, SPACE_TIMER, OFF_DIVIDER0, 32'h1));
        send_txn(make_txn(OP_TICK, SPACE_TIMER, 6'h0, 32'h0));
        send_txn(make_txn(OP_READ, SPACE_TIMER, OFF_VALUE0, 32'h0));
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_txn(random_txn());
        wait_drain();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_requests++;
        repeat (30) send_txn(random_txn());
        wait_drain();
    endtask

    task automatic report_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (error_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected transaction, actual 0x%h", $time, o_out_data);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                result_count++;
                if (o_out_data.bad_access) bad_seen++;
                if (o_out_data.irq) irq_seen++;
                if (o_out_data.read_data !== want.read_data)
                    report_field("read_data", want.read_data, o_out_data.read_data);
                if (o_out_data.bad_access !== want.bad_access)
                    report_field("bad_access", 32'(want.bad_access), 32'(o_out_data.bad_access));
                if (o_out_data.irq !== want.irq)
                    report_field("irq", 32'(want.irq), 32'(o_out_data.irq));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_hold_left <= 0;
        end else if (rx_hold_left != 0) begin
            out_stall <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else if (holds_served != hold_requests) begin
            out_stall <= 1'b1;
            rx_hold_left <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_stall <= 1'b1;
            rx_hold_left <= $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        clear_timer_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;
        test_register_access();
        test_timer_steps();
        test_random_traffic(280);
        test_backpressure();
        idle_on = 1'b0;
        test_random_traffic(140);
        repeat (8) @(posedge i_clk);
        $display("checked %0d transactions: %0d ticks, %0d bad accesses, %0d with irq set",
                 result_count, tick_count, bad_seen, irq_seen);
        $display("register map, timer modes, prescaler, match interrupts and backpressure covered");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
